// ===== rtl/core/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg: shared types for the Catmull-Rom path evaluator
// Input and result word layouts, function codes and the store depth.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int MAX_POINTS = 64;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic               func;
    logic [5:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]        query_t;
  } crp_in_t;

  typedef struct packed {
    logic               path_ok;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [31:0] slope_z;
  } crp_out_t;

endpackage

// ===== rtl/core/crp_horner.sv =====
// ----------------------------------------------------------------------------
// crp_horner: one Horner step with the shared multiplier
// Computes R(h * t) + addend, with R rounding half up from Q16 scaling.
// ----------------------------------------------------------------------------
module crp_horner (
  input  logic signed [39:0] h,
  input  logic        [16:0] t,
  input  logic signed [39:0] addend,
  output logic signed [39:0] res
);
  logic signed [57:0] prod;
  logic signed [57:0] rnd;

  // Horner values stay within 40 bits for 32-bit points and t up to one.
  assign prod = h * $signed({1'b0, t});
  assign rnd  = prod + 58'sd32768;
  assign res  = 40'(rnd >>> 16) + addend;
endmodule

// ===== rtl/core/catmull_rom_path_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_path_evaluator_top: uniform Catmull-Rom path evaluator
// Stores up to MAX_POINTS 3D points and evaluates position and slope.
// ----------------------------------------------------------------------------
// A write word stores one point and is accepted only while no query is being
// evaluated or waiting. A query word is evaluated for each of the three axes
// in turn: the four neighbours are fetched from the single-port point memory
// (its read data is registered behind the address), the cubic coefficients
// are formed, and one shared multiplier then runs the three position Horner
// steps and the two slope steps in turn. The result then moves into the
// output register as soon as no earlier result is still stalled there; with
// fewer than two points in use the evaluation is skipped and a zero word is
// presented. The input is stalled while a query is being evaluated and while
// its result waits for the output register, so a waiting result does hold
// back the input.
module catmull_rom_path_evaluator_top import crp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  crp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output crp_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_COEF, S_POS, S_SLP, S_DONE} st_t;

  logic [95:0] mem [MAX_POINTS];
  logic [95:0] rd_q;

  st_t         st_r;
  logic [6:0]  count_r;
  logic [CW-1:0] n_r;
  logic [AW-1:0] seg_r;
  logic [16:0] t_r;
  logic [1:0]  axis_r;
  logic [2:0]  step_r;
  logic signed [39:0] p_r [4];
  logic signed [39:0] c_r, d_r, h_r;
  logic        out_valid_r;
  crp_out_t    out_r;
  crp_out_t    wrk_r;

  logic signed [39:0] pa, pb, pc, pd, addend, hres;
  logic [AW-1:0] rd_addr;
  logic signed [31:0] sel;
  logic [33:0] scaled;
  logic [17:0] segw;
  logic [CW-1:0] nclip;
  logic signed [39:0] half;
  logic signed [31:0] satv;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {25'd0, count_r};
  assign in_stall   = (st_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  // store read address for step_r 0..3 of the neighbour fetch
  always_comb begin
    logic [AW:0] a;
    a = {1'b0, seg_r} + (AW+1)'(step_r) - (AW+1)'(1);
    rd_addr = a[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && in_data.func == FUNC_WRITE &&
        32'(in_data.point_index) < MAX_POINTS)
      mem[in_data.point_index[AW-1:0]] <= {in_data.coord_x, in_data.coord_y, in_data.coord_z};
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    case (axis_r)
      2'd0:    sel = rd_q[95:64];
      2'd1:    sel = rd_q[63:32];
      default: sel = rd_q[31:0];
    endcase
  end

  // neighbours with ghost points at the ends
  assign pb = p_r[1];
  assign pc = p_r[2];
  assign pa = (seg_r == '0) ? (2 * pb - pc) : p_r[0];
  assign pd = ({1'b0, seg_r} + (AW+1)'(2) >= (AW+1)'(n_r)) ? (2 * pc - pb) : p_r[3];

  always_comb begin
    case (st_r)
      S_POS: addend = (step_r == 3'd0) ? c_r : (step_r == 3'd1) ? (pc - pa) : 2 * pb;
      default: addend = (step_r == 3'd0) ? 2 * c_r : (pc - pa);
    endcase
  end

  crp_horner u_horner (.h(h_r), .t(t_r), .addend(addend), .res(hres));

  always_comb begin
    logic signed [40:0] s;
    s = ({hres[39], hres} + 41'sd1) >>> 1;
    half = s[39:0];
    if (half > 40'sd2147483647)       satv = 32'sh7fffffff;
    else if (half < -40'sd2147483648) satv = 32'sh80000000;
    else                              satv = half[31:0];
  end

  assign nclip  = (count_r > 7'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count_r);
  assign scaled = ((in_data.query_t == 16'hffff) ? 17'h10000 : {1'b0, in_data.query_t})
                  * 17'(nclip - 1'b1);
  assign segw   = (scaled[33:16] > 18'(nclip - 2'd2)) ? 18'(nclip - 2'd2) : scaled[33:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        count_r <= cfg_pwdata[6:0];
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_valid && !in_stall && in_data.func == FUNC_QUERY) begin
          if (nclip < 2) begin
            wrk_r <= '0;
            st_r  <= S_DONE;
          end else begin
            n_r    <= nclip;
            seg_r  <= segw[AW-1:0];
            t_r    <= 17'(scaled - {segw, 16'd0});
            axis_r <= 2'd0;
            step_r <= 3'd0;
            wrk_r.path_ok <= 1'b1;
            st_r   <= S_RD;
          end
        end
        S_RD: begin
          // read data is registered behind the address
          if (step_r != 3'd0) p_r[2'(step_r - 3'd1)] <= 40'(sel);
          if (step_r == 3'd4) st_r <= S_COEF;
          else step_r <= step_r + 3'd1;
        end
        S_COEF: begin
          c_r    <= 2 * pa - 5 * pb + 4 * pc - pd;
          d_r    <= -pa + 3 * pb - 3 * pc + pd;
          h_r    <= -pa + 3 * pb - 3 * pc + pd;
          step_r <= 3'd0;
          st_r   <= S_POS;
        end
        S_POS: begin
          if (step_r == 3'd2) begin
            case (axis_r)
              2'd0:    wrk_r.pos_x <= satv;
              2'd1:    wrk_r.pos_y <= satv;
              default: wrk_r.pos_z <= satv;
            endcase
            h_r    <= 3 * d_r;
            step_r <= 3'd0;
            st_r   <= S_SLP;
          end else begin
            h_r    <= hres;
            step_r <= step_r + 3'd1;
          end
        end
        S_SLP: begin
          if (step_r == 3'd1) begin
            case (axis_r)
              2'd0:    wrk_r.slope_x <= satv;
              2'd1:    wrk_r.slope_y <= satv;
              default: wrk_r.slope_z <= satv;
            endcase
            step_r <= 3'd0;
            if (axis_r == 2'd2) st_r <= S_DONE;
            else begin
              axis_r <= axis_r + 2'd1;
              st_r   <= S_RD;
            end
          end else begin
            h_r    <= hres;
            step_r <= step_r + 3'd1;
          end
        end
        S_DONE: begin
          // The finished word waits here while the previous one is unread.
          if (!out_valid_r) begin
            out_r       <= wrk_r;
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Catmull-Rom path evaluator
// Loads control points, sweeps the point count over several settings and
// checks every query result against a fixed-point path predictor, with
// random idling on the input and random stalls on the result channel.
// ----------------------------------------------------------------------------
module tb_top;
  import crp_pkg::*;

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam int STORE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;

  class path_scoreboard;
    longint pts[3][STORE_DEPTH];
    int unsigned point_count;
    crp_out_t pending[$];
    int errors;

    function longint round16(longint v);
      return (v + 32768) >>> 16;
    endfunction

    function logic signed [31:0] sat_half(longint v);
      longint h;
      h = (v + 1) >>> 1;
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      return h[31:0];
    endfunction

    // Evaluates one axis of the segment; ghost neighbours mirror the end point.
    function void eval_axis(int ax, int seg, int n, longint lt,
                            output logic signed [31:0] pos,
                            output logic signed [31:0] slope);
      longint p0, p1, p2, p3, a, b, c, d, h;
      p1 = pts[ax][seg];
      p2 = pts[ax][seg + 1];
      p0 = (seg > 0) ? pts[ax][seg - 1] : 2 * p1 - p2;
      p3 = (seg + 2 < n) ? pts[ax][seg + 2] : 2 * p2 - p1;
      a = 2 * p1;
      b = p2 - p0;
      c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      d = -p0 + 3 * p1 - 3 * p2 + p3;
      h = round16(d * lt) + c;
      h = round16(h * lt) + b;
      h = round16(h * lt) + a;
      pos = sat_half(h);
      h = round16(3 * d * lt) + 2 * c;
      h = round16(h * lt) + b;
      slope = sat_half(h);
    endfunction

    function crp_out_t evaluate_path(logic [15:0] qt);
      crp_out_t r;
      int n, seg;
      longint t, scaled;
      logic signed [31:0] p[3], s[3];
      r = '0;
      n = (point_count > STORE_DEPTH) ? STORE_DEPTH : point_count;
      if (n < 2) return r;
      t = (qt >= 16'hFFFF) ? 65536 : qt;
      scaled = t * (n - 1);
      seg = int'(scaled >>> 16);
      if (seg > n - 2) seg = n - 2;
      t = scaled - longint'(seg) * 65536;
      for (int ax = 0; ax < 3; ax++) eval_axis(ax, seg, n, t, p[ax], s[ax]);
      r.path_ok = 1'b1;
      r.pos_x = p[0];
      r.pos_y = p[1];
      r.pos_z = p[2];
      r.slope_x = s[0];
      r.slope_y = s[1];
      r.slope_z = s[2];
      return r;
    endfunction

    function void note_input(crp_in_t w);
      if (w.func == FUNC_WRITE) begin
        pts[0][w.point_index] = longint'(w.coord_x);
        pts[1][w.point_index] = longint'(w.coord_y);
        pts[2][w.point_index] = longint'(w.coord_z);
      end else begin
        pending.push_back(evaluate_path(w.query_t));
      end
    endfunction

    function void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(crp_out_t got);
      crp_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("path_ok", e.path_ok, got.path_ok);
      check_field("pos_x", e.pos_x, got.pos_x);
      check_field("pos_y", e.pos_y, got.pos_y);
      check_field("pos_z", e.pos_z, got.pos_z);
      check_field("slope_x", e.slope_x, got.slope_x);
      check_field("slope_y", e.slope_y, got.slope_y);
      check_field("slope_z", e.slope_z, got.slope_z);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  crp_in_t in_data;
  logic out_valid;
  logic out_stall;
  crp_out_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  path_scoreboard sb;
  bit quiet;
  int stall_left;
  int cycles;

  catmull_rom_path_evaluator_top DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side stalls in random bursts while not quiet.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic send_word(crp_in_t w);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // A trailing write word may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_point_count(int unsigned value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_POINT_COUNT;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    sb.point_count = value & 7'h7F;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 16'hFFFF) - 32'sd32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic crp_in_t make_write(int idx);
    crp_in_t w;
    w = '0;
    w.func = FUNC_WRITE;
    w.point_index = 6'(idx);
    w.coord_x = pick_coord();
    w.coord_y = pick_coord();
    w.coord_z = pick_coord();
    w.query_t = 16'($urandom);
    return w;
  endfunction

  function automatic crp_in_t make_query(logic [15:0] qt);
    crp_in_t w;
    w = '0;
    w.func = FUNC_QUERY;
    w.point_index = 6'($urandom);
    w.coord_x = $urandom;
    w.coord_y = $urandom;
    w.coord_z = $urandom;
    w.query_t = qt;
    return w;
  endfunction

  function automatic logic [15:0] pick_t();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned counts[9] = '{2, 3, 64, 127, 5, 1, 17, 0, 40};
    int sent;
    crp_in_t w;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    quiet = 1'b0;
    stall_left = 0;
    cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // With no points in use a query gives zeros and a cleared flag.
    send_word(make_query(16'h0000));
    send_word(make_query(16'hFFFF));

    // Fill the whole store so no query ever reads an unwritten entry.
    for (int i = 0; i < STORE_DEPTH; i++) begin
      w = make_write(i);
      if (i == 0) begin
        w.coord_x = 32'h7FFF_FFFF;
        w.coord_y = 32'h8000_0000;
        w.coord_z = 32'h0001_0000;
      end else if (i == 1) begin
        w.coord_x = 32'h8000_0000;
        w.coord_y = 32'h7FFF_FFFF;
        w.coord_z = 32'hFFFF_0000;
      end
      send_word(w);
    end
    wait_drained();

    set_point_count(2);
    send_word(make_query(16'h0000));
    send_word(make_query(16'h0001));
    send_word(make_query(16'h8000));
    send_word(make_query(16'hFFFE));
    send_word(make_query(16'hFFFF));
    wait_drained();
    set_point_count(64);
    send_word(make_query(16'h0000));
    send_word(make_query(16'hFFFF));
    send_word(make_query(16'hFBFF));
    wait_drained();

    sent = 0;
    foreach (counts[k]) begin
      set_point_count(counts[k]);
      for (int j = 0; j < 225; j++) begin
        if (sent > 1800) quiet = 1'b1;
        if ($urandom_range(0, 2) == 0) send_word(make_write($urandom_range(0, 63)));
        else send_word(make_query(pick_t()));
        sent++;
      end
      wait_drained();
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
